### rtl/swat_pkg.sv
// ----------------------------------------------------------------------------
// swat_pkg: shared types for the sliding window acknowledge tracker
// Slot chain token, broadcast command and slot update codes.
// ----------------------------------------------------------------------------
`default_nettype none

package swat_pkg;

    localparam int unsigned DefaultWindow  = 8;
    localparam int unsigned DefaultInitSeq = 0;

    // Accumulator width in the token, sized for the largest window (64 slots)
    localparam int unsigned AccW = 7;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SEND_EMPTY,
        OP_SEND_ACKED,
        OP_ACK_UPTO,
        OP_RESEND,
        OP_RESEND_ONLY,
        OP_ACK_ONE,
        OP_ACK_FIRST,
        OP_CLEAR
    } slot_op_t;

    typedef enum logic {
        PASS_SCAN,
        PASS_COUNT
    } pass_t;

    // Token handed from cell to cell, one cell per cycle
    typedef struct packed {
        logic            valid;
        pass_t           pass;
        logic            f_used;
        logic            used_acked;
        logic [7:0]      used_tries;
        logic            f_empty;
        logic            f_acked;
        logic            f_unacked;
        logic [AccW-1:0] acc;
        logic            bar;
    } token_t;

    // Broadcast to every cell
    typedef struct packed {
        logic       en;
        slot_op_t   op;
        logic [7:0] seq;
        logic       incl;
        logic       barrier;
        logic [7:0] new_seq;
    } cmd_t;

endpackage

`default_nettype wire

### rtl/sliding_window_ack_tracker_top.sv
// ----------------------------------------------------------------------------
// sliding_window_ack_tracker_top: sender side of a windowed ack/resend protocol
// Tracks in-flight slots in a chain of cells and reports one result per event.
// ----------------------------------------------------------------------------
// Channel   Dir  Contents
// s_*       in   tuser: kind; tdata: seq_in, has_sequence, free_space_in, is_barrier
// m_*       out  tuser: status; tdata: slot window and counter snapshot
// cfg_*     in   resend_limit write
//
// Between transfer and result a token walks the slot chain once to search,
// all slots update together in the apply state, then a second token walks
// the chain to count in-flight slots. One event is in work at a time, so a
// new event is not taken before the previous one has loaded its result; one
// is taken while the previous result waits in the output register on m_tready,
// and its own result holds in S_DONE until that register drains.
// Synchronous active-low reset empties all slots and zeroes the counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_ack_tracker_top #(
    parameter int unsigned WINDOW           = swat_pkg::DefaultWindow,
    parameter int unsigned INITIAL_SEQUENCE = swat_pkg::DefaultInitSeq
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [23:0]  s_tdata,  // seq_in, has_sequence, free_space_in, is_barrier
    input  wire logic [3:0]   s_tuser,  // kind
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [151:0]      m_tdata,  // seq_out, inflight_count, pending_barrier,
                                        // space_known, space_left, resend_active,
                                        // acks, rejects, resends, sends totals
    output logic [2:0]        m_tuser,  // status
    input  wire logic         cfg_wr_en,
    input  wire logic [7:0]   cfg_wr_data
);
    import swat_pkg::*;

    localparam logic [3:0] KIND_SEND    = 4'd0;
    localparam logic [3:0] KIND_SYNC_O  = 4'd1;
    localparam logic [3:0] KIND_SYNC_R  = 4'd2;
    localparam logic [3:0] KIND_SYNC_Q  = 4'd3;
    localparam logic [3:0] KIND_BAD_CRC = 4'd4;
    localparam logic [3:0] KIND_PROTO   = 4'd5;
    localparam logic [3:0] KIND_RESEND  = 4'd6;
    localparam logic [3:0] KIND_OK      = 4'd7;
    localparam logic [3:0] KIND_ERROR   = 4'd8;
    localparam logic [3:0] KIND_CLEAR   = 4'd10;
    localparam logic [3:0] KIND_RESYNC  = 4'd11;

    localparam logic [2:0] ST_IGNORED  = 3'd0;
    localparam logic [2:0] ST_HANDLED  = 3'd1;
    localparam logic [2:0] ST_RESEND   = 3'd2;
    localparam logic [2:0] ST_LIMIT    = 3'd3;
    localparam logic [2:0] ST_EXPECTED = 3'd4;
    localparam logic [2:0] ST_ERROR    = 3'd5;
    localparam logic [2:0] ST_SENT     = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_GO,
        S_SCAN_WAIT,
        S_APPLY,
        S_COUNT_GO,
        S_COUNT_WAIT,
        S_DONE
    } state_t;

    state_t      state_reg;
    logic [3:0]  kind_reg;
    logic [7:0]  seq_in_reg;
    logic        has_seq_reg;
    logic [7:0]  space_in_reg;
    logic        barrier_in_reg;
    token_t      scan_reg;
    logic [2:0]  status_reg, status_next;
    logic [7:0]  seq_out_reg, seq_out_next;
    logic [3:0]  inflight_reg;
    logic        pend_bar_reg;
    logic [7:0]  next_seq_reg, next_seq_next;
    logic [7:0]  expected_reg, expected_next;
    logic        resend_flag_reg, resend_flag_next;
    logic [7:0]  rx_space_reg, rx_space_next;
    logic        rx_valid_reg, rx_valid_next;
    logic [31:0] acks_reg, acks_next;
    logic [31:0] rejects_reg, rejects_next;
    logic [31:0] resends_reg, resends_next;
    logic [31:0] sends_reg, sends_next;
    logic [7:0]  limit_reg;

    cmd_t        cmd;
    token_t      tok_head;
    token_t      chain [WINDOW];
    token_t      tok_tail;
    logic        pending_hit;
    logic [7:0]  tries_new;
    logic        out_load;

    assign tok_tail = chain[WINDOW-1];

    always_comb begin
        tok_head       = '0;
        tok_head.valid = (state_reg == S_SCAN_GO) || (state_reg == S_COUNT_GO);
        tok_head.pass  = (state_reg == S_COUNT_GO) ? PASS_COUNT : PASS_SCAN;
    end

    genvar g;
    generate
        for (g = 0; g < WINDOW; g++) begin : g_cell
            swat_cell #(.WINDOW(WINDOW)) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .cmd     (cmd),
                .tok_in  ((g == 0) ? tok_head : chain[(g == 0) ? 0 : g-1]),
                .tok_out (chain[g])
            );
        end
    endgenerate

    assign pending_hit = scan_reg.f_used && !scan_reg.used_acked;
    assign tries_new   = (scan_reg.used_tries == 8'hFF) ? scan_reg.used_tries
                                                        : scan_reg.used_tries + 8'd1;

    // Event decode: evaluated in the apply cycle from the search results
    always_comb begin
        cmd              = '0;
        cmd.op           = OP_NONE;
        cmd.seq          = seq_in_reg;
        cmd.incl         = (kind_reg == KIND_SYNC_O);
        cmd.barrier      = barrier_in_reg;
        cmd.new_seq      = next_seq_reg;
        status_next      = ST_IGNORED;
        seq_out_next     = '0;
        next_seq_next    = next_seq_reg;
        expected_next    = expected_reg;
        resend_flag_next = resend_flag_reg;
        rx_space_next    = rx_space_reg;
        rx_valid_next    = rx_valid_reg;
        acks_next        = acks_reg;
        rejects_next     = rejects_reg;
        resends_next     = resends_reg;
        sends_next       = sends_reg;
        unique case (kind_reg)
            KIND_SEND: begin
                if ((rx_valid_reg && rx_space_reg == 8'd0) ||
                    !(scan_reg.f_empty || scan_reg.f_acked)) begin
                    status_next = ST_FULL;
                end else begin
                    cmd.op        = scan_reg.f_empty ? OP_SEND_EMPTY : OP_SEND_ACKED;
                    seq_out_next  = next_seq_reg;
                    next_seq_next = next_seq_reg + 8'd1;
                    if (rx_valid_reg && rx_space_reg != 8'd0)
                        rx_space_next = rx_space_reg - 8'd1;
                    sends_next  = sends_reg + 32'd1;
                    status_next = ST_SENT;
                end
            end
            KIND_SYNC_O, KIND_SYNC_R, KIND_SYNC_Q: begin
                rx_space_next = space_in_reg;
                rx_valid_next = 1'b1;
                if (kind_reg == KIND_SYNC_O) begin
                    resend_flag_next = 1'b0;
                    if (scan_reg.f_used) begin
                        cmd.op      = OP_ACK_UPTO;
                        acks_next   = acks_reg + 32'(scan_reg.acc);
                        status_next = ST_HANDLED;
                    end
                end else if (kind_reg == KIND_SYNC_R) begin
                    if (!pending_hit) begin
                        rejects_next = rejects_reg + 32'd1;
                    end else if (!resend_flag_reg) begin
                        cmd.op           = OP_RESEND;
                        acks_next        = acks_reg + 32'(scan_reg.acc);
                        resends_next     = resends_reg + 32'd1;
                        rejects_next     = rejects_reg + 32'd1;
                        resend_flag_next = 1'b1;
                        seq_out_next     = seq_in_reg;
                        status_next      = (tries_new > limit_reg) ? ST_LIMIT : ST_RESEND;
                    end
                end
            end
            KIND_BAD_CRC, KIND_ERROR: begin
                rejects_next = rejects_reg + 32'd1;
                status_next  = ST_ERROR;
            end
            KIND_PROTO: begin
                expected_next = seq_in_reg;
                rejects_next  = rejects_reg + 32'd1;
                status_next   = ST_EXPECTED;
            end
            KIND_RESEND: begin
                if (!resend_flag_reg) begin
                    if (!has_seq_reg) begin
                        rejects_next = rejects_reg + 32'd1;
                        status_next  = ST_HANDLED;
                    end else if (!pending_hit) begin
                        rejects_next = rejects_reg + 32'd1;
                    end else begin
                        cmd.op           = OP_RESEND_ONLY;
                        resends_next     = resends_reg + 32'd1;
                        rejects_next     = rejects_reg + 32'd1;
                        resend_flag_next = 1'b1;
                        seq_out_next     = seq_in_reg;
                        status_next      = (tries_new > limit_reg) ? ST_LIMIT : ST_RESEND;
                    end
                end
            end
            KIND_OK: begin
                if (has_seq_reg) begin
                    if (scan_reg.f_used) begin
                        cmd.op    = OP_ACK_ONE;
                        acks_next = acks_reg + 32'd1;
                    end
                end else if (scan_reg.f_unacked) begin
                    cmd.op    = OP_ACK_FIRST;
                    acks_next = acks_reg + 32'd1;
                end
                status_next = ST_HANDLED;
            end
            KIND_CLEAR, KIND_RESYNC: begin
                cmd.op        = OP_CLEAR;
                rx_space_next = '0;
                rx_valid_next = 1'b0;
                if (kind_reg == KIND_RESYNC) begin
                    next_seq_next    = expected_reg;
                    resend_flag_next = 1'b0;
                end
                status_next = ST_HANDLED;
            end
            default: ;
        endcase
        cmd.en = (state_reg == S_APPLY);
    end

    // load the output register once the previous result has left
    assign out_load = (state_reg == S_DONE) && (!m_tvalid || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            m_tvalid        <= 1'b0;
            m_tdata         <= '0;
            m_tuser         <= '0;
            next_seq_reg    <= 8'(INITIAL_SEQUENCE);
            expected_reg    <= '0;
            resend_flag_reg <= 1'b0;
            rx_space_reg    <= '0;
            rx_valid_reg    <= 1'b0;
            acks_reg        <= '0;
            rejects_reg     <= '0;
            resends_reg     <= '0;
            sends_reg       <= '0;
            limit_reg       <= 8'd3;
        end else begin
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            if (out_load) begin
                m_tvalid <= 1'b1;
                m_tuser  <= status_reg;
                m_tdata  <= {1'b0, sends_reg, resends_reg, rejects_reg, acks_reg,
                             resend_flag_reg, rx_space_reg, rx_valid_reg, pend_bar_reg,
                             inflight_reg, seq_out_reg};
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        kind_reg       <= s_tuser;
                        seq_in_reg     <= s_tdata[7:0];
                        has_seq_reg    <= s_tdata[8];
                        space_in_reg   <= s_tdata[16:9];
                        barrier_in_reg <= s_tdata[17];
                        state_reg      <= S_SCAN_GO;
                    end
                end
                S_SCAN_GO: state_reg <= S_SCAN_WAIT;
                S_SCAN_WAIT: begin
                    if (tok_tail.valid) begin
                        scan_reg  <= tok_tail;
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    status_reg      <= status_next;
                    seq_out_reg     <= seq_out_next;
                    next_seq_reg    <= next_seq_next;
                    expected_reg    <= expected_next;
                    resend_flag_reg <= resend_flag_next;
                    rx_space_reg    <= rx_space_next;
                    rx_valid_reg    <= rx_valid_next;
                    acks_reg        <= acks_next;
                    rejects_reg     <= rejects_next;
                    resends_reg     <= resends_next;
                    sends_reg       <= sends_next;
                    state_reg       <= S_COUNT_GO;
                end
                S_COUNT_GO: state_reg <= S_COUNT_WAIT;
                S_COUNT_WAIT: begin
                    if (tok_tail.valid) begin
                        // saturate the in-flight count at 15
                        inflight_reg <= (tok_tail.acc > AccW'(15)) ? 4'hF
                                                                   : tok_tail.acc[3:0];
                        pend_bar_reg <= tok_tail.bar;
                        state_reg    <= S_DONE;
                    end
                end
                S_DONE: begin
                    // hold until the result register is free
                    if (out_load) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

`default_nettype wire

### rtl/swat_cell.sv
// ----------------------------------------------------------------------------
// swat_cell: one window slot
// Holds one slot, evaluates the passing token and applies broadcast updates.
// ----------------------------------------------------------------------------
`default_nettype none

module swat_cell #(
    parameter int unsigned WINDOW = swat_pkg::DefaultWindow
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire swat_pkg::cmd_t   cmd,
    input  wire swat_pkg::token_t tok_in,
    output swat_pkg::token_t      tok_out
);
    import swat_pkg::*;

    logic [7:0] seq_reg;
    logic       used_reg;
    logic       acked_reg;
    logic       bar_reg;
    logic [7:0] tries_reg;
    logic       sel_used_reg;
    logic       sel_empty_reg;
    logic       sel_acked_reg;
    logic       sel_unacked_reg;
    token_t     tok_reg;
    token_t     tok_next;

    logic       match;
    logic       pending;
    logic [7:0] diff;
    logic       in_range;
    logic       upto_hit;
    logic [7:0] tries_inc;

    assign match     = used_reg && (seq_reg == cmd.seq);
    assign pending   = used_reg && !acked_reg;
    assign diff      = cmd.seq - seq_reg;
    assign in_range  = {1'b0, diff} < 9'(WINDOW);
    assign upto_hit  = pending && ((seq_reg == cmd.seq) ? cmd.incl : in_range);
    assign tries_inc = (tries_reg == 8'hFF) ? tries_reg : tries_reg + 8'd1;

    always_comb begin
        tok_next = tok_in;
        if (tok_in.pass == PASS_SCAN) begin
            if (match && !tok_in.f_used) begin
                tok_next.f_used     = 1'b1;
                tok_next.used_acked = acked_reg;
                tok_next.used_tries = tries_reg;
            end
            if (!used_reg) tok_next.f_empty = 1'b1;
            if (acked_reg) tok_next.f_acked = 1'b1;
            if (pending)   tok_next.f_unacked = 1'b1;
            tok_next.acc = tok_in.acc + AccW'(upto_hit);
        end else begin
            tok_next.acc = tok_in.acc + AccW'(pending);
            tok_next.bar = tok_in.bar | (pending & bar_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg         <= '0;
            used_reg        <= 1'b0;
            acked_reg       <= 1'b0;
            bar_reg         <= 1'b0;
            tries_reg       <= '0;
            sel_used_reg    <= 1'b0;
            sel_empty_reg   <= 1'b0;
            sel_acked_reg   <= 1'b0;
            sel_unacked_reg <= 1'b0;
            tok_reg         <= '0;
        end else begin
            tok_reg <= tok_next;
            if (tok_in.valid && tok_in.pass == PASS_SCAN) begin
                sel_used_reg    <= match && !tok_in.f_used;
                sel_empty_reg   <= !used_reg && !tok_in.f_empty;
                sel_acked_reg   <= acked_reg && !tok_in.f_acked;
                sel_unacked_reg <= pending && !tok_in.f_unacked;
            end
            if (cmd.en) begin
                unique case (cmd.op)
                    OP_SEND_EMPTY, OP_SEND_ACKED: begin
                        if ((cmd.op == OP_SEND_EMPTY) ? sel_empty_reg : sel_acked_reg) begin
                            seq_reg   <= cmd.new_seq;
                            used_reg  <= 1'b1;
                            acked_reg <= 1'b0;
                            bar_reg   <= cmd.barrier;
                            tries_reg <= '0;
                        end
                    end
                    OP_ACK_UPTO: begin
                        if (upto_hit) acked_reg <= 1'b1;
                    end
                    OP_RESEND: begin
                        if (upto_hit) acked_reg <= 1'b1;
                        if (sel_used_reg) tries_reg <= tries_inc;
                    end
                    OP_RESEND_ONLY: begin
                        if (sel_used_reg) tries_reg <= tries_inc;
                    end
                    OP_ACK_ONE: begin
                        if (sel_used_reg) acked_reg <= 1'b1;
                    end
                    OP_ACK_FIRST: begin
                        if (sel_unacked_reg) acked_reg <= 1'b1;
                    end
                    OP_CLEAR: begin
                        seq_reg   <= '0;
                        used_reg  <= 1'b0;
                        acked_reg <= 1'b0;
                        bar_reg   <= 1'b0;
                        tries_reg <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire
